// ===== rtl/spsd_pkg.sv =====
// Shared types and codes for the strict-priority slice dispatcher.
package spsd_pkg;

    localparam logic FUNC_ENQ  = 1'b0;
    localparam logic FUNC_DISP = 1'b1;

    localparam logic [2:0] ST_ENQUEUED  = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_ISSUED    = 3'd2;
    localparam logic [2:0] ST_THROTTLED = 3'd3;
    localparam logic [2:0] ST_IDLE      = 3'd4;

    localparam logic [0:0] CFG_LEVEL_COUNT = 1'b0;
    localparam logic [0:0] CFG_CORE_LIMIT  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [7:0]  priority_req;
        logic [31:0] job_tag;
        logic [15:0] slice_count;
        logic [31:0] exec_time;
        logic [9:0]  core_running;
        logic [15:0] slices_accepted;
    } spsd_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] issue_tag;
        logic [2:0]  issue_level;
        logic [15:0] issue_offset;
        logic [15:0] issue_slices;
        logic        job_finished;
        logic [47:0] level_buffered_time;
        logic [9:0]  pending_total;
    } spsd_out_t;

    typedef struct packed {
        logic [31:0] tag;
        logic [15:0] slices;
        logic [31:0] ptime;
    } spsd_job_t;

endpackage

// ===== rtl/spsd_job_ram.sv =====
// Job storage memory shared by all priority levels, with a registered read port.
module spsd_job_ram
    import spsd_pkg::*;
#(
    parameter int AW = 9
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  spsd_job_t        wdata,
    input  logic [AW-1:0]    raddr,
    output spsd_job_t        rdata
);

    spsd_job_t mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/strict_priority_slice_dispatcher_core.sv =====
// Top level of the strict-priority slice dispatcher.
//
// Usage: drive in and pulse start while busy is low. func selects enqueue
// or dispatch. Each transaction yields exactly one result on out, marked
// by a one-cycle done strobe.
// Timing: start registers the request and addresses the head entry in the
// job memory; the read state then uses the memory data to update level
// state and register out and done. busy is high in the read state; a new
// start is accepted only in idle. The level scan is a priority encoder
// over per-level fill and slice counts (highest level wins); the job memory
// is written on a non-full enqueue and read at the head on dispatch.
// Configuration: cfg_we writes register cfg_index (0 level_count,
// 1 core_buffer_limit) immediately; write only while busy is low.
// Reset: all queues empty, no job in progress, buffered times zero,
// level_count = 8, core_buffer_limit = 0. Memory is not cleared.
// The receiver cannot stall: out is valid from the done cycle until the next result.
module strict_priority_slice_dispatcher_core
    import spsd_pkg::*;
#(
    parameter int MAX_LEVELS  = 8,
    parameter int QUEUE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  spsd_in_t    in,
    output logic        busy,
    output logic        done,
    output spsd_out_t   out,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = LW + QW;
    localparam int SW = $clog2(MAX_LEVELS * QUEUE_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;

    logic [1:0]  state_reg, state_next;
    logic [3:0]  level_count_reg;
    logic [9:0]  core_limit_reg;

    logic [QW-1:0] head_reg [MAX_LEVELS];
    logic [FW-1:0] fill_reg [MAX_LEVELS];
    logic [15:0]   left_reg [MAX_LEVELS];
    logic [47:0]   buf_reg  [MAX_LEVELS];
    logic [31:0]   ctag_reg [MAX_LEVELS];
    logic [15:0]   csl_reg  [MAX_LEVELS];
    logic [31:0]   ctime_reg[MAX_LEVELS];
    logic [SW-1:0] pend_reg;

    spsd_in_t    in_reg;
    logic [LW-1:0] lv_reg;
    logic        hit_reg;
    logic        cont_reg;
    logic        thr_reg;
    logic        full_reg;

    spsd_out_t   out_reg;
    logic        done_reg;

    logic [4:0]  nlev;
    logic [LW-1:0] enq_lv;
    logic [LW-1:0] sel_lv;
    logic        sel_hit;
    logic        sel_cont;
    logic [QW:0]   wr_sum;
    logic [QW-1:0] wr_slot;
    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    spsd_job_t   ram_wdata;
    spsd_job_t   ram_rdata;

    always_comb
    begin
        if (level_count_reg == 4'd0)
            nlev = 5'd1;
        else if ({1'b0, level_count_reg} > 5'(MAX_LEVELS))
            nlev = 5'(MAX_LEVELS);
        else
            nlev = {1'b0, level_count_reg};
        if ({5'd0, in.priority_req} >= {8'd0, nlev} - 13'd0)
            enq_lv = LW'(nlev - 5'd1);
        else
            enq_lv = LW'(in.priority_req);
        sel_lv   = '0;
        sel_hit  = 1'b0;
        sel_cont = 1'b0;
        for (int i = 0; i < MAX_LEVELS; i++)
        begin
            if (5'(i) < nlev && (left_reg[i] != 16'd0 || fill_reg[i] != '0))
            begin
                sel_lv   = LW'(i);
                sel_hit  = 1'b1;
                sel_cont = (left_reg[i] != 16'd0);
            end
        end
    end

    assign wr_sum    = {1'b0, head_reg[enq_lv]} + (QW+1)'(fill_reg[enq_lv]);
    assign wr_slot   = (wr_sum >= (QW+1)'(QUEUE_DEPTH)) ?
                       QW'(wr_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(wr_sum);
    assign ram_we    = (state_reg == S_IDLE) && start && in.func == FUNC_ENQ &&
                       fill_reg[enq_lv] < FW'(QUEUE_DEPTH);
    assign ram_waddr = {enq_lv, wr_slot};
    assign ram_wdata = '{tag: in.job_tag, slices: in.slice_count, ptime: in.exec_time};
    assign ram_raddr = {sel_lv, head_reg[sel_lv]};

    spsd_job_ram #(.AW(AW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  state_next = start ? S_READ : S_IDLE;
            S_READ:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            in_reg   <= in;
            lv_reg   <= (in.func == FUNC_ENQ) ? enq_lv : sel_lv;
            hit_reg  <= sel_hit;
            cont_reg <= sel_cont;
            thr_reg  <= core_limit_reg != 10'd0 && in.core_running >= core_limit_reg;
            full_reg <= fill_reg[enq_lv] >= FW'(QUEUE_DEPTH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        logic [15:0] tot;
        logic [15:0] lft;
        logic [15:0] n;
        logic [31:0] ct;
        logic [47:0] b;
        spsd_out_t   o;
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            level_count_reg <= 4'd8;
            core_limit_reg  <= 10'd0;
            done_reg        <= 1'b0;
            pend_reg        <= '0;
            out_reg         <= '0;
            for (int i = 0; i < MAX_LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                fill_reg[i]  <= '0;
                left_reg[i]  <= '0;
                buf_reg[i]   <= '0;
                ctag_reg[i]  <= '0;
                csl_reg[i]   <= '0;
                ctime_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_READ);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LEVEL_COUNT: level_count_reg <= cfg_data[3:0];
                    CFG_CORE_LIMIT:  core_limit_reg  <= cfg_data;
                    default:         ;
                endcase
            end
            if (ram_we)
            begin
                fill_reg[enq_lv] <= fill_reg[enq_lv] + FW'(1);
                buf_reg[enq_lv]  <= buf_reg[enq_lv] + {16'd0, in.exec_time};
                pend_reg         <= pend_reg + SW'(1);
            end
            if (state_reg == S_READ)
            begin
                o = '0;
                if (in_reg.func == FUNC_ENQ)
                begin
                    o.status = full_reg ? ST_FULL : ST_ENQUEUED;
                    o.issue_level = 3'(lv_reg);
                    o.level_buffered_time = buf_reg[lv_reg];
                end
                else if (thr_reg)
                    o.status = ST_THROTTLED;
                else if (!hit_reg)
                    o.status = ST_IDLE;
                else
                begin
                    if (cont_reg)
                    begin
                        tot = csl_reg[lv_reg];
                        lft = left_reg[lv_reg];
                        ct  = ctime_reg[lv_reg];
                        o.issue_tag = ctag_reg[lv_reg];
                        o.issue_offset = tot - lft;
                    end
                    else
                    begin
                        tot = ram_rdata.slices;
                        lft = ram_rdata.slices;
                        ct  = ram_rdata.ptime;
                        o.issue_tag = ram_rdata.tag;
                        ctag_reg[lv_reg]  <= ram_rdata.tag;
                        csl_reg[lv_reg]   <= ram_rdata.slices;
                        ctime_reg[lv_reg] <= ram_rdata.ptime;
                        head_reg[lv_reg]  <= (head_reg[lv_reg] == QW'(QUEUE_DEPTH - 1)) ?
                                             '0 : head_reg[lv_reg] + QW'(1);
                        fill_reg[lv_reg]  <= fill_reg[lv_reg] - FW'(1);
                        pend_reg          <= pend_reg - SW'(1);
                    end
                    n = (in_reg.slices_accepted < lft) ? in_reg.slices_accepted : lft;
                    left_reg[lv_reg] <= lft - n;
                    b = buf_reg[lv_reg];
                    if (lft == n)
                    begin
                        b = b - {16'd0, ct};
                        o.job_finished = 1'b1;
                    end
                    buf_reg[lv_reg] <= b;
                    o.status = ST_ISSUED;
                    o.issue_level = 3'(lv_reg);
                    o.issue_slices = n;
                    o.level_buffered_time = b;
                end
                if (in_reg.func != FUNC_ENQ && hit_reg && !thr_reg && !cont_reg)
                    o.pending_total = (pend_reg - SW'(1) > SW'(1023)) ? 10'd1023
                                      : 10'(pend_reg - SW'(1));
                else
                    o.pending_total = (pend_reg > SW'(1023)) ? 10'd1023 : 10'(pend_reg);
                out_reg <= o;
            end
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign out  = out_reg;

endmodule
